// ----- sv/tokcls_pkg.sv -----
// ----------------------------------------------------------------------------
// tokcls_pkg - shared types and tables for the token classifier
// Scan modes, token kind codes, character constants and the keyword tables
// used to narrow keyword candidates one character at a time.
// ----------------------------------------------------------------------------
`default_nettype none

package tokcls_pkg;

  // Default saturation point for token lengths
  localparam int unsigned MAX_TOKEN_LEN_DEF = 255;

  // Field widths
  localparam int unsigned CH_W    = 8;
  localparam int unsigned KIND_W  = 4;
  localparam int unsigned START_W = 32;
  localparam int unsigned TLEN_W  = 8;

  // Keyword table geometry
  localparam int unsigned KW_COUNT  = 11;
  localparam int unsigned KW_MAXLEN = 6;
  localparam int unsigned KW_POS_W  = 3;
  localparam int unsigned KW_LEN_W  = 3;

  // Scan mode, one-hot
  typedef enum logic [3:0] {
    MODE_IDLE = 4'b0001,
    MODE_NUM  = 4'b0010,
    MODE_WORD = 4'b0100,
    MODE_CMT  = 4'b1000
  } scan_mode_t;

  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [KW_COUNT-1:0] kw_mask_t;

  // Token kind codes
  localparam kind_t KIND_NUM    = 4'd0;
  localparam kind_t KIND_ID     = 4'd1;
  localparam kind_t KIND_DTYPE  = 4'd2;
  localparam kind_t KIND_IF     = 4'd3;
  localparam kind_t KIND_ELSE   = 4'd4;
  localparam kind_t KIND_ELIF   = 4'd5;
  localparam kind_t KIND_SWITCH = 4'd6;
  localparam kind_t KIND_WHILE  = 4'd7;
  localparam kind_t KIND_FOR    = 4'd8;
  localparam kind_t KIND_DO     = 4'd9;

  localparam kw_mask_t KW_ALL = '1;

  // Character constants
  localparam logic [CH_W-1:0] CH_HASH = 8'h23;
  localparam logic [CH_W-1:0] CH_NL   = 8'h0A;
  localparam logic [CH_W-1:0] CH_USCR = 8'h5F;

  // Keyword spellings, zero padded
  localparam logic [CH_W-1:0] KW_TEXT [KW_COUNT][KW_MAXLEN] = '{
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00},
    '{"c", "h", "a", "r", 8'h00, 8'h00},
    '{"d", "o", "u", "b", "l", "e"},
    '{"f", "l", "o", "a", "t", 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00},
    '{"e", "l", "i", "f", 8'h00, 8'h00},
    '{"s", "w", "i", "t", "c", "h"},
    '{"w", "h", "i", "l", "e", 8'h00},
    '{"f", "o", "r", 8'h00, 8'h00, 8'h00},
    '{"d", "o", 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [KW_LEN_W-1:0] KW_LEN [KW_COUNT] = '{
    3'd3, 3'd4, 3'd6, 3'd5, 3'd2, 3'd4, 3'd4, 3'd6, 3'd5, 3'd3, 3'd2
  };

  localparam kind_t KW_KIND [KW_COUNT] = '{
    KIND_DTYPE, KIND_DTYPE, KIND_DTYPE, KIND_DTYPE, KIND_IF, KIND_ELSE,
    KIND_ELIF, KIND_SWITCH, KIND_WHILE, KIND_FOR, KIND_DO
  };

  // Classify one byte into the mode it would start
  function automatic scan_mode_t classify(input logic [CH_W-1:0] c);
    scan_mode_t cls;
    if (c >= "0" && c <= "9") begin
      cls = MODE_NUM;
    end else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_USCR) begin
      cls = MODE_WORD;
    end else if (c == CH_HASH) begin
      cls = MODE_CMT;
    end else begin
      cls = MODE_IDLE;
    end
    return cls;
  endfunction

endpackage

`default_nettype wire

// ----- sv/token_classifier.sv -----
// ----------------------------------------------------------------------------
// token_classifier - byte-serial tokenizer for C-like source text
// Scans source bytes and emits one descriptor (kind, start, length) for each
// number, identifier or keyword token when the token ends.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one source byte per item in in_tdata[7:0]. in_tlast marks
//   the end of the text: it flushes any pending token and returns offsets,
//   mode and run state to their reset values; its byte is ignored.
//   Output channel: one token descriptor per item. out_tuser carries the kind
//   and the length overflow flag, out_tdata the start offset and length.
//   Throughput: one input item per cycle while the output register is not
//   blocked by an untaken result. The mode, length and keyword mask update is
//   combinational logic from the scan state registers back into them.
//   Latency: the descriptor of a token is valid in the cycle after the item
//   that ends it is accepted. Items that end nothing produce no output.
//   Stall: a waiting result sits in the output register; in_tready is high
//   only while that register is empty or is drained in the same cycle, so
//   input stops for every cycle in which an untaken result waits.
//   Reset: rst_n low clears the scan state to idle, the byte offset to zero
//   and drops any result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module token_classifier #(
  parameter int unsigned MAX_TOKEN_LEN = tokcls_pkg::MAX_TOKEN_LEN_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Source byte channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] ch
  input  wire logic        in_tlast,   // end_of_text
  // Token descriptor channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [31:0] token_start, [39:32] token_length
  output logic [4:0]       out_tuser   // [3:0] token_kind, [4] length_overflow
);

  import tokcls_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_TOKEN_LEN + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TOKEN_LEN);

  // Scan state
  scan_mode_t          mode_r, mode_nxt;
  logic [LEN_W-1:0]    run_len_r, run_len_nxt;
  logic [START_W-1:0]  run_start_r, run_start_nxt;
  logic [START_W-1:0]  byte_off_r, byte_off_nxt;
  kw_mask_t            cand_r, cand_nxt;
  logic                run_ovf_r, run_ovf_nxt;

  // Result register
  logic                out_valid_r;
  kind_t               res_kind_r;
  logic [START_W-1:0]  res_start_r;
  logic [TLEN_W-1:0]   res_len_r;
  logic                res_ovf_r;

  logic                in_fire;
  logic [CH_W-1:0]     ch;
  scan_mode_t          cls;
  logic                pending;
  logic                emit;
  kind_t               flush_kind;

  // Run extension inputs and results
  logic                start_run;
  logic [LEN_W-1:0]    base_len;
  kw_mask_t            base_cand;
  logic                base_ovf;
  kw_mask_t            keep;
  logic [LEN_W-1:0]    ext_len;
  kw_mask_t            ext_cand;
  logic                ext_ovf;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign ch        = in_tdata[CH_W-1:0];
  assign cls       = classify(ch);
  assign pending   = (mode_r == MODE_NUM) || (mode_r == MODE_WORD);

  // Kind of the pending token: first surviving keyword of matching length
  always_comb begin
    flush_kind = (mode_r == MODE_WORD) ? KIND_ID : KIND_NUM;
    if (mode_r == MODE_WORD && !run_ovf_r) begin
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
        if (cand_r[k] && run_len_r == LEN_W'(KW_LEN[k])) begin
          flush_kind = KW_KIND[k];
        end
      end
    end
  end

  // Extend the current run, or a fresh one on the same byte
  assign start_run = (mode_r != cls);
  assign base_len  = start_run ? '0 : run_len_r;
  assign base_cand = start_run ? KW_ALL : cand_r;
  assign base_ovf  = start_run ? 1'b0 : run_ovf_r;

  always_comb begin
    keep = '0;
    if (base_len < LEN_W'(KW_MAXLEN)) begin
      for (int k = 0; k < KW_COUNT; k++) begin
        if (base_len < LEN_W'(KW_LEN[k]) &&
            KW_TEXT[k][base_len[KW_POS_W-1:0]] == ch) begin
          keep[k] = 1'b1;
        end
      end
    end
  end

  assign ext_cand = (cls == MODE_WORD) ? (base_cand & keep) : base_cand;
  assign ext_len  = (base_len < LEN_MAX) ? (base_len + LEN_W'(1)) : base_len;
  assign ext_ovf  = base_ovf || (base_len >= LEN_MAX);

  // Next scan state and emit decision for an accepted item
  always_comb begin
    mode_nxt      = mode_r;
    run_len_nxt   = run_len_r;
    run_start_nxt = run_start_r;
    byte_off_nxt  = byte_off_r;
    cand_nxt      = cand_r;
    run_ovf_nxt   = run_ovf_r;
    emit          = 1'b0;
    if (in_tlast) begin
      emit          = pending;
      mode_nxt      = MODE_IDLE;
      run_len_nxt   = '0;
      run_start_nxt = '0;
      byte_off_nxt  = '0;
      cand_nxt      = KW_ALL;
      run_ovf_nxt   = 1'b0;
    end else begin
      byte_off_nxt = byte_off_r + START_W'(1);
      unique case (mode_r)
        MODE_CMT: begin
          if (ch == CH_NL) begin
            mode_nxt = MODE_IDLE;
          end
        end
        MODE_IDLE, MODE_NUM, MODE_WORD: begin
          emit = pending && start_run;
          if (cls == MODE_NUM || cls == MODE_WORD) begin
            mode_nxt      = cls;
            run_len_nxt   = ext_len;
            run_ovf_nxt   = ext_ovf;
            cand_nxt      = ext_cand;
            if (start_run) begin
              run_start_nxt = byte_off_r;
            end
          end else begin
            mode_nxt      = cls;
            run_len_nxt   = '0;
            run_start_nxt = '0;
            cand_nxt      = KW_ALL;
            run_ovf_nxt   = 1'b0;
          end
        end
        default: begin
          mode_nxt = MODE_IDLE;
        end
      endcase
    end
  end

  // Scan state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      run_len_r   <= '0;
      run_start_r <= '0;
      byte_off_r  <= '0;
      cand_r      <= KW_ALL;
      run_ovf_r   <= 1'b0;
    end else if (in_fire) begin
      mode_r      <= mode_nxt;
      run_len_r   <= run_len_nxt;
      run_start_r <= run_start_nxt;
      byte_off_r  <= byte_off_nxt;
      cand_r      <= cand_nxt;
      run_ovf_r   <= run_ovf_nxt;
    end
  end

  // Output valid: load on emit, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload: hold until the next emitted token
  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      res_kind_r  <= flush_kind;
      res_start_r <= run_start_r;
      res_len_r   <= TLEN_W'(run_len_r);
      res_ovf_r   <= run_ovf_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_len_r, res_start_r};
  assign out_tuser  = {res_ovf_r, res_kind_r};

  // End of text leaves the scanner idle at offset zero
  a_eot_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tlast) |=> (mode_r == MODE_IDLE && byte_off_r == '0))
    else $error("end of text did not reset scan state");

  // Bytes inside a comment never produce a token
  a_cmt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && mode_r == MODE_CMT) |-> !emit)
    else $error("token emitted from comment mode");

  // Run length saturates at the maximum
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    run_len_r <= LEN_MAX)
    else $error("run length beyond maximum");

  // An overflowed run sits at the saturation length
  a_ovf_len: assert property (@(posedge clk) disable iff (!rst_n)
    run_ovf_r |-> (run_len_r == LEN_MAX))
    else $error("overflow flag without saturated length");

  // A new result is only loaded into an empty or draining output register
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !in_fire)
    else $error("input accepted while result register is blocked");

endmodule

`default_nettype wire
